// ===== hdl/cme_pkg.sv =====
// ----------------------------------------------------------------------------
// cme_pkg
// Types, constants and the condition table shared by the conditional
// multiply-accumulate unit, its register file and its checker.
// ----------------------------------------------------------------------------
package cme_pkg;

	localparam int NUM_REGS = 16;
	localparam int REG_AW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	// Status word flag positions.
	localparam int FLAG_N = 31;
	localparam int FLAG_Z = 30;

	typedef logic [3:0]  reg_idx_t;
	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		KIND_LOAD_REG    = 2'd0,
		KIND_LOAD_STATUS = 2'd1,
		KIND_EXEC        = 2'd2,
		KIND_NONE        = 2'd3
	} item_kind_t;

	typedef enum logic [3:0] {
		COND_EQ = 4'd0,
		COND_NE = 4'd1,
		COND_CS = 4'd2,
		COND_CC = 4'd3,
		COND_MI = 4'd4,
		COND_PL = 4'd5,
		COND_VS = 4'd6,
		COND_VC = 4'd7,
		COND_HI = 4'd8,
		COND_LS = 4'd9,
		COND_GE = 4'd10,
		COND_LT = 4'd11,
		COND_GT = 4'd12,
		COND_LE = 4'd13,
		COND_AL = 4'd14,
		COND_NV = 4'd15
	} cond_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_OPER = 2'd1,
		ST_ACC  = 2'd2
	} state_t;

	// One write port beat into the register file.
	typedef struct packed {
		logic     en;
		reg_idx_t addr;
		word_t    data;
	} rf_wr_t;

	function automatic logic reg_in_range(reg_idx_t idx);
		return 32'(idx) < NUM_REGS;
	endfunction

	// nzcv holds N, Z, C, V from the highest bit down.
	function automatic logic cond_holds(cond_t cc, logic [3:0] nzcv);
		logic n, z, c, v, ok;
		n = nzcv[3];
		z = nzcv[2];
		c = nzcv[1];
		v = nzcv[0];
		unique case (cc)
			COND_EQ: ok = z;
			COND_NE: ok = !z;
			COND_CS: ok = c;
			COND_CC: ok = !c;
			COND_MI: ok = n;
			COND_PL: ok = !n;
			COND_VS: ok = v;
			COND_VC: ok = !v;
			COND_HI: ok = c && !z;
			COND_LS: ok = !c || z;
			COND_GE: ok = (n == v);
			COND_LT: ok = (n != v);
			COND_GT: ok = !z && (n == v);
			COND_LE: ok = z || (n != v);
			COND_AL: ok = 1'b1;
			COND_NV: ok = 1'b0;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// ===== hdl/cond_multiply_accumulate_exec.sv =====
// ----------------------------------------------------------------------------
// cond_multiply_accumulate_exec
// Conditional MUL/MLA execution unit with its own register file and
// NZCV status word.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on the s_ channel is one item: load a register, load the
// status word, or execute a multiply (selected by s_tuser). Every item gives
// exactly one result beat on the m_ channel carrying the written value, the
// status word after the item and the wrote flag.
// Loads, the unused kind and executes whose condition fails go straight to
// the output register: the result is valid in the cycle after the input beat,
// and the next item can be taken as soon as the receiver accepts it. An
// executed multiply goes through the accept, ST_OPER and ST_ACC states: the
// register file has two read ports, so Rm and Rs are read at accept, Rn in
// ST_OPER next to the registered multiply, and the add, flag update and
// write-back happen in ST_ACC. Reset clears the status word and marks every
// register as zero through valid bits; the block is ready once reset ends.
// When the receiver stalls, the result stays in the output register and a
// new input beat is taken only once that register is being emptied.
// ----------------------------------------------------------------------------
module cond_multiply_accumulate_exec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] cond_code, [4] accumulate, [5] set_flags, [9:6] dest_index,
	// [13:10] addend_index, [17:14] mult_s_index, [21:18] mult_m_index,
	// [53:22] load_value, [55:54] zero
	input  logic [55:0] s_tdata,
	// [1:0] kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] result_value, [63:32] status_word
	output logic [63:0] m_tdata,
	// [0] wrote
	output logic [0:0]  m_tuser
);
	import cme_pkg::*;

	state_t     state_q, state_d;
	item_kind_t in_kind;
	cond_t      in_cond;
	logic       in_acc, in_setf, in_fire, cond_ok;
	reg_idx_t   in_dest, in_addend, in_rs, in_rm;
	word_t      in_load;

	logic       item_acc_q, item_setf_q;
	reg_idx_t   item_dest_q, item_addend_q;
	word_t      prod_s2, acc_sum;

	rf_wr_t     rf_wr;
	reg_idx_t   rd_addr_a, rd_addr_b;
	word_t      rf_rd_a, rf_rd_b;

	word_t      status_q, status_d;
	logic       status_load;

	logic       out_load, out_wrote;
	word_t      out_result, out_status;
	logic       m_tvalid_q, m_wrote_q;
	word_t      m_result_q, m_status_q;

	assign in_kind   = item_kind_t'(s_tuser);
	assign in_cond   = cond_t'(s_tdata[3:0]);
	assign in_acc    = s_tdata[4];
	assign in_setf   = s_tdata[5];
	assign in_dest   = s_tdata[9:6];
	assign in_addend = s_tdata[13:10];
	assign in_rs     = s_tdata[17:14];
	assign in_rm     = s_tdata[21:18];
	assign in_load   = s_tdata[53:22];

	assign in_fire = s_tvalid && s_tready;
	assign cond_ok = cond_holds(in_cond, status_q[31:28]);
	assign acc_sum = prod_s2 + (item_acc_q ? rf_rd_a : '0);

	cme_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (rf_wr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rf_rd_a),
		.rd_data_b (rf_rd_b)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && in_kind == KIND_EXEC && cond_ok) begin
					state_d = ST_OPER;
				end
			end
			ST_OPER: state_d = ST_ACC;
			ST_ACC:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
		// Port A serves Rm at accept and Rn in ST_OPER.
		rd_addr_a   = (state_q == ST_OPER) ? item_addend_q : in_rm;
		rd_addr_b   = in_rs;
		rf_wr       = '0;
		status_d    = status_q;
		status_load = 1'b0;
		out_load    = 1'b0;
		out_wrote   = 1'b0;
		out_result  = '0;
		out_status  = status_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (in_kind)
						KIND_LOAD_REG: begin
							rf_wr.en   = 1'b1;
							rf_wr.addr = in_dest;
							rf_wr.data = in_load;
							out_load   = 1'b1;
						end
						KIND_LOAD_STATUS: begin
							status_d    = in_load;
							status_load = 1'b1;
							out_status  = in_load;
							out_load    = 1'b1;
						end
						KIND_EXEC: out_load = !cond_ok;
						KIND_NONE: out_load = 1'b1;
						default:   out_load = 1'b1;
					endcase
				end
			end
			ST_OPER: begin
			end
			ST_ACC: begin
				if (item_setf_q) begin
					status_d[FLAG_N] = acc_sum[31];
					status_d[FLAG_Z] = (acc_sum == '0);
					status_load      = 1'b1;
				end
				out_status = status_d;
				out_wrote  = reg_in_range(item_dest_q);
				out_result = out_wrote ? acc_sum : '0;
				rf_wr.en   = out_wrote;
				rf_wr.addr = item_dest_q;
				rf_wr.data = acc_sum;
				out_load   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			status_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (status_load) begin
				status_q <= status_d;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_acc_q    <= in_acc;
			item_setf_q   <= in_setf;
			item_dest_q   <= in_dest;
			item_addend_q <= in_addend;
		end
		if (state_q == ST_OPER) begin
			prod_s2 <= rf_rd_a * rf_rd_b;
		end
		if (out_load) begin
			m_result_q <= out_result;
			m_status_q <= out_status;
			m_wrote_q  <= out_wrote;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {m_status_q, m_result_q};
	assign m_tuser[0] = m_wrote_q;

endmodule

// ===== hdl/cme_regfile.sv =====
// ----------------------------------------------------------------------------
// cme_regfile
// Register file memory: one write port, two registered read ports.
// Per-entry valid bits make unwritten entries and out-of-range indexes
// read as zero.
// ----------------------------------------------------------------------------
module cme_regfile (
	input  logic             clk,
	input  logic             arst_n,
	input  cme_pkg::rf_wr_t  wr,
	input  cme_pkg::reg_idx_t rd_addr_a,
	input  cme_pkg::reg_idx_t rd_addr_b,
	output cme_pkg::word_t   rd_data_a,
	output cme_pkg::word_t   rd_data_b
);
	import cme_pkg::*;

	word_t               mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	word_t               data_a_q;
	word_t               data_b_q;
	logic                hit_a_q;
	logic                hit_b_q;

	always_ff @(posedge clk) begin
		if (wr.en && reg_in_range(wr.addr)) begin
			mem[wr.addr[REG_AW-1:0]] <= wr.data;
		end
		data_a_q <= mem[rd_addr_a[REG_AW-1:0]];
		data_b_q <= mem[rd_addr_b[REG_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			if (wr.en && reg_in_range(wr.addr)) begin
				valid_q[wr.addr[REG_AW-1:0]] <= 1'b1;
			end
			hit_a_q <= reg_in_range(rd_addr_a) && valid_q[rd_addr_a[REG_AW-1:0]];
			hit_b_q <= reg_in_range(rd_addr_b) && valid_q[rd_addr_b[REG_AW-1:0]];
		end
	end

	assign rd_data_a = hit_a_q ? data_a_q : '0;
	assign rd_data_b = hit_b_q ? data_b_q : '0;

endmodule

// ===== hdl/cme_checker.sv =====
// ----------------------------------------------------------------------------
// cme_checker
// Port-level checks for the conditional multiply-accumulate unit, bound to
// the top level.
// ----------------------------------------------------------------------------
module cme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser
);
	import cme_pkg::*;

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// No result is pending in the first cycle after reset is released.
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

	// A beat that did not write Rd reports a zero result value.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
		else $error("nonzero result without a write");

	// A status load shows up in the very next result beat.
	a_status_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_LOAD_STATUS
		|=> m_tvalid && m_tdata[63:32] == $past(s_tdata[53:22]))
		else $error("status load not reflected in result");

	// A register load answers next cycle with no write reported.
	a_reg_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_LOAD_REG
		|=> m_tvalid && !m_tuser[0] && m_tdata[31:0] == 32'd0)
		else $error("register load result malformed");

endmodule

bind cond_multiply_accumulate_exec cme_checker u_cme_checker (.*);

// ===== tb/cme_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cme_result_checker
// Watches both stream channels of the conditional multiply-accumulate unit.
// It keeps its own copy of the register file and the status word. From each
// input beat it works out the result that beat must give. Each result beat is
// then compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cme_result_checker
	import cme_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [0:0]  m_tuser,
	output int          err_count,
	output int          pending_cnt,
	output int          written_cnt
);

	typedef struct packed {
		word_t value;
		logic  wrote;
		word_t status;
	} outcome_t;

	word_t    shadow_regs [NUM_REGS];
	word_t    shadow_status;
	outcome_t expected_q [$];

	initial begin
		for (int i = 0; i < NUM_REGS; i++) begin
			shadow_regs[i] = '0;
		end
		shadow_status = '0;
		err_count     = 0;
		pending_cnt   = 0;
		written_cnt   = 0;
	end

	// Pairs of codes share a base test; the odd code of each pair inverts it.
	function automatic logic cond_passes(cond_t cc, logic [3:0] nzcv);
		logic n, z, c, v, base;
		{n, z, c, v} = nzcv;
		case (cc)
			COND_EQ, COND_NE: base = z;
			COND_CS, COND_CC: base = c;
			COND_MI, COND_PL: base = n;
			COND_VS, COND_VC: base = v;
			COND_HI, COND_LS: base = c & ~z;
			COND_GE, COND_LT: base = (n == v);
			COND_GT, COND_LE: base = ~z & (n == v);
			default:          base = 1'b1;
		endcase
		return cc[0] ? ~base : base;
	endfunction

	function automatic word_t shadow_read(reg_idx_t idx);
		if (int'(idx) < NUM_REGS) begin
			return shadow_regs[idx];
		end
		return '0;
	endfunction

	// Applies one item to the shadow state and returns the result it gives.
	function automatic outcome_t apply_item(logic [1:0] kind_bits, logic [55:0] data);
		outcome_t   res;
		item_kind_t kind;
		cond_t      cc;
		logic       acc, setf;
		reg_idx_t   rd, rn, rs, rm;
		word_t      lv, prod;
		kind = item_kind_t'(kind_bits);
		cc   = cond_t'(data[3:0]);
		acc  = data[4];
		setf = data[5];
		rd   = data[9:6];
		rn   = data[13:10];
		rs   = data[17:14];
		rm   = data[21:18];
		lv   = data[53:22];
		res.value = '0;
		res.wrote = 1'b0;
		case (kind)
			KIND_LOAD_REG: begin
				if (int'(rd) < NUM_REGS) begin
					shadow_regs[rd] = lv;
				end
			end
			KIND_LOAD_STATUS: begin
				shadow_status = lv;
			end
			KIND_EXEC: begin
				if (cond_passes(cc, shadow_status[31:28])) begin
					prod = shadow_read(rm) * shadow_read(rs);
					if (acc) begin
						prod = prod + shadow_read(rn);
					end
					if (setf) begin
						shadow_status[FLAG_N] = prod[31];
						shadow_status[FLAG_Z] = (prod == '0);
					end
					if (int'(rd) < NUM_REGS) begin
						shadow_regs[rd] = prod;
						res.value       = prod;
						res.wrote       = 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.status = shadow_status;
		return res;
	endfunction

	task automatic flag_mismatch(string field, word_t want, word_t got);
		if (err_count < 40) begin
			$display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h",
				$time, field, want, got);
		end
		err_count++;
	endtask

	// The result side is handled first, since a result leaving at the same
	// edge as an input beat belongs to an earlier item.
	always @(posedge clk) begin : watch
		outcome_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.value  = m_tdata[31:0];
				got.status = m_tdata[63:32];
				got.wrote  = m_tuser[0];
				if (expected_q.size() == 0) begin
					if (err_count < 40) begin
						$display("%0t: result beat with nothing expected: value 0x%08h",
							$time, got.value);
					end
					err_count++;
				end else begin
					want = expected_q.pop_front();
					if (got.value !== want.value) begin
						flag_mismatch("result_value", want.value, got.value);
					end
					if (got.wrote !== want.wrote) begin
						flag_mismatch("wrote", 32'(want.wrote), 32'(got.wrote));
					end
					if (got.status !== want.status) begin
						flag_mismatch("status_word", want.status, got.status);
					end
					if (want.wrote) begin
						written_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_q.push_back(apply_item(s_tuser, s_tdata));
			end
			pending_cnt = expected_q.size();
		end
	end

endmodule

// ===== tb/cond_multiply_accumulate_exec_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cond_multiply_accumulate_exec_tb
// Drives register loads, status loads and conditional MUL/MLA items into the
// execution unit. A short directed part covers operand extremes and the
// condition corner cases. Random items follow, with idle cycles on both
// sides. The checker predicts every result and counts the mismatches.
// ----------------------------------------------------------------------------
module cond_multiply_accumulate_exec_tb;
	import cme_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int STALL_LIMIT  = 2000;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [0:0]  m_tuser;

	int          err_count, pending_cnt, written_cnt;
	int          idle_cycles = 0;
	logic        calm        = 1'b0;
	int          kind_seen [4] = '{0, 0, 0, 0};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	cond_multiply_accumulate_exec u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	cme_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.err_count   (err_count),
		.pending_cnt (pending_cnt),
		.written_cnt (written_cnt)
	);

	// Outside the calm stretch, the receiver holds off about seven percent of the time.
	always @(negedge clk) begin
		m_tready = calm || ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Called just after a falling edge; returns just after the next falling
	// edge following the accepted beat.
	task automatic send_item(item_kind_t kind, cond_t cc, logic acc, logic setf,
		reg_idx_t rd, reg_idx_t rn, reg_idx_t rs, reg_idx_t rm, word_t lv);
		while (!calm && $urandom_range(99) < 7) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = {2'b00, lv, rm, rs, rn, rd, setf, acc, cc};
		do begin
			@(posedge clk);
		end while (!s_tready);
		kind_seen[kind]++;
		@(negedge clk);
	endtask

	// Operand values lean toward the corners so that zero, negative and
	// wrapping results come up often.
	function automatic word_t pick_word();
		case ($urandom_range(9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h0000_0001;
			4:       return 32'($urandom_range(15));
			5:       return 32'h0001_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic cond_t pick_cond();
		if ($urandom_range(3) == 0) begin
			return COND_AL;
		end
		return cond_t'($urandom_range(15));
	endfunction

	initial begin : stimulus
		int          useful;
		int          pick;
		item_kind_t  kind;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Operand extremes, then flag setting to negative and zero.
		send_item(KIND_LOAD_REG, COND_EQ, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 32'h0000_0000);
		send_item(KIND_LOAD_REG, COND_EQ, 1'b0, 1'b0, 4'd1, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFF);
		send_item(KIND_LOAD_REG, COND_EQ, 1'b0, 1'b0, 4'd2, 4'd0, 4'd0, 4'd0, 32'h8000_0000);
		send_item(KIND_LOAD_REG, COND_EQ, 1'b0, 1'b0, 4'd3, 4'd0, 4'd0, 4'd0, 32'h0000_0001);
		send_item(KIND_LOAD_REG, COND_EQ, 1'b0, 1'b0, 4'd15, 4'd0, 4'd0, 4'd0, 32'h0000_0007);
		send_item(KIND_EXEC, COND_AL, 1'b0, 1'b1, 4'd5, 4'd0, 4'd1, 4'd1, 32'h0);
		send_item(KIND_EXEC, COND_AL, 1'b1, 1'b1, 4'd6, 4'd2, 4'd1, 4'd3, 32'h0);
		send_item(KIND_EXEC, COND_AL, 1'b0, 1'b1, 4'd7, 4'd0, 4'd0, 4'd1, 32'h0);
		send_item(KIND_EXEC, COND_EQ, 1'b0, 1'b1, 4'd8, 4'd0, 4'd2, 4'd3, 32'h0);
		// Never condition, then Rd doubling as every source register.
		send_item(KIND_EXEC, COND_NV, 1'b1, 1'b1, 4'd9, 4'd1, 4'd1, 4'd1, 32'hFFFF_FFFF);
		send_item(KIND_EXEC, COND_AL, 1'b1, 1'b0, 4'd15, 4'd15, 4'd15, 4'd15, 32'h0);
		send_item(KIND_LOAD_STATUS, COND_EQ, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0,
			32'hFFFF_FFFF);
		send_item(KIND_EXEC, COND_MI, 1'b0, 1'b0, 4'd10, 4'd0, 4'd3, 4'd3, 32'h0);
		send_item(KIND_EXEC, COND_PL, 1'b0, 1'b1, 4'd11, 4'd0, 4'd3, 4'd3, 32'h0);
		// C and V set, N and Z clear.
		send_item(KIND_LOAD_STATUS, COND_EQ, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0,
			32'h3000_0000);
		send_item(KIND_EXEC, COND_HI, 1'b0, 1'b0, 4'd12, 4'd0, 4'd1, 4'd2, 32'h0);
		send_item(KIND_EXEC, COND_GE, 1'b0, 1'b0, 4'd13, 4'd0, 4'd1, 4'd2, 32'h0);
		send_item(KIND_EXEC, COND_LT, 1'b1, 1'b1, 4'd13, 4'd1, 4'd1, 4'd2, 32'h0);
		send_item(KIND_EXEC, COND_LE, 1'b1, 1'b1, 4'd14, 4'd3, 4'd1, 4'd1, 32'h0);
		send_item(KIND_NONE, COND_NV, 1'b1, 1'b1, 4'd15, 4'd15, 4'd15, 4'd15,
			32'hFFFF_FFFF);
		send_item(KIND_NONE, COND_EQ, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 32'h0);

		// Random part: mostly executes over registers with corner values, a
		// steady share of status loads to move the flags, and some noise.
		useful = 0;
		while (useful < RANDOM_ITEMS) begin
			calm = (useful >= 350) && (useful < 500);
			pick = $urandom_range(99);
			if (pick < 50) begin
				kind = KIND_EXEC;
			end else if (pick < 78) begin
				kind = KIND_LOAD_REG;
			end else if (pick < 94) begin
				kind = KIND_LOAD_STATUS;
			end else begin
				kind = KIND_NONE;
			end
			if (kind != KIND_NONE) begin
				useful++;
			end
			send_item(kind, pick_cond(), 1'($urandom), 1'($urandom),
				4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
				(kind == KIND_LOAD_STATUS) ? $urandom : pick_word());
		end
		calm     = 1'b0;
		s_tvalid = 1'b0;

		while (pending_cnt != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		$display("Items: %0d register loads, %0d status loads, %0d executes, %0d unused kind.",
			kind_seen[KIND_LOAD_REG], kind_seen[KIND_LOAD_STATUS], kind_seen[KIND_EXEC],
			kind_seen[KIND_NONE]);
		$display("Executes that wrote a register: %0d; mismatches: %0d.",
			written_cnt, err_count);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
